// ===== design/pmfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfp_pkg
// Types, constants and decode functions for the PTPv2 message field parser.
// ----------------------------------------------------------------------------
package pmfp_pkg;

  // Saturation point of the octet offset (range 64 to 127)
  localparam int MAX_OFFSET_DEF = 64;

  // Result queue depth; one octet can push up to three records
  localparam int QDEPTH     = 5;
  localparam int MAX_PUSH   = 3;

  localparam logic [15:0] ACCEPT_MASK_RST = 16'h0F0F;

  localparam logic [7:0] HDR_OCTETS = 8'd34;
  localparam logic [7:0] TS_OCTETS  = 8'd10;
  localparam logic [7:0] RSV_OCTETS = 8'd10;
  localparam logic [7:0] ANN_OCTETS = 8'd30;
  localparam logic [3:0] TYPE_MASK  = 4'hF;

  // Field tags
  localparam logic [4:0] TAG_MSG_TYPE    = 5'd0;
  localparam logic [4:0] TAG_TRANSPORT   = 5'd1;
  localparam logic [4:0] TAG_VERSION     = 5'd2;
  localparam logic [4:0] TAG_MSG_LENGTH  = 5'd3;
  localparam logic [4:0] TAG_DOMAIN      = 5'd4;
  localparam logic [4:0] TAG_FLAGS       = 5'd5;
  localparam logic [4:0] TAG_CORRECTION  = 5'd6;
  localparam logic [4:0] TAG_CLOCK_ID    = 5'd7;
  localparam logic [4:0] TAG_PORT_NUM    = 5'd8;
  localparam logic [4:0] TAG_SEQ_ID      = 5'd9;
  localparam logic [4:0] TAG_CONTROL     = 5'd10;
  localparam logic [4:0] TAG_LOG_INTVL   = 5'd11;
  localparam logic [4:0] TAG_TS_SEC      = 5'd12;
  localparam logic [4:0] TAG_TS_NSEC     = 5'd13;
  localparam logic [4:0] TAG_REQ_CLK_ID  = 5'd14;
  localparam logic [4:0] TAG_REQ_PORT    = 5'd15;
  localparam logic [4:0] TAG_UTC_OFFSET  = 5'd16;
  localparam logic [4:0] TAG_GM_PRIO1    = 5'd17;
  localparam logic [4:0] TAG_CLK_CLASS   = 5'd18;
  localparam logic [4:0] TAG_CLK_ACCUR   = 5'd19;
  localparam logic [4:0] TAG_LOG_VAR     = 5'd20;
  localparam logic [4:0] TAG_GM_PRIO2    = 5'd21;
  localparam logic [4:0] TAG_GM_ID       = 5'd22;
  localparam logic [4:0] TAG_STEPS_REM   = 5'd23;
  localparam logic [4:0] TAG_TIME_SRC    = 5'd24;
  localparam logic [4:0] TAG_VERDICT     = 5'd25;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK         = 2'd0;
  localparam logic [1:0] VERDICT_HDR_SHORT  = 2'd1;
  localparam logic [1:0] VERDICT_TYPE       = 2'd2;
  localparam logic [1:0] VERDICT_BODY_SHORT = 2'd3;

  // Message types that select a body layout
  localparam logic [3:0] MT_SYNC         = 4'h0;
  localparam logic [3:0] MT_DELAY_REQ    = 4'h1;
  localparam logic [3:0] MT_PDELAY_REQ   = 4'h2;
  localparam logic [3:0] MT_PDELAY_RESP  = 4'h3;
  localparam logic [3:0] MT_FOLLOW_UP    = 4'h8;
  localparam logic [3:0] MT_DELAY_RESP   = 4'h9;
  localparam logic [3:0] MT_PDELAY_RFU   = 4'hA;
  localparam logic [3:0] MT_ANNOUNCE     = 4'hB;

  typedef enum logic [2:0] {
    LAY_NONE,
    LAY_TS,
    LAY_PDREQ,
    LAY_PORTID,
    LAY_ANNOUNCE
  } layout_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [63:0] field_value;
    logic        last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] tag;
    logic [3:0] nbytes;
  } fld_t;

  function automatic layout_t layout_of(input logic [3:0] mtype);
    layout_t lay;
    case (mtype)
      MT_SYNC, MT_DELAY_REQ, MT_FOLLOW_UP:        lay = LAY_TS;
      MT_PDELAY_REQ:                              lay = LAY_PDREQ;
      MT_PDELAY_RESP, MT_DELAY_RESP, MT_PDELAY_RFU: lay = LAY_PORTID;
      MT_ANNOUNCE:                                lay = LAY_ANNOUNCE;
      default:                                    lay = LAY_NONE;
    endcase
    return lay;
  endfunction

  function automatic logic [7:0] needed_len(input layout_t lay);
    logic [7:0] n;
    case (lay)
      LAY_TS:               n = HDR_OCTETS + TS_OCTETS;
      LAY_PDREQ, LAY_PORTID: n = HDR_OCTETS + TS_OCTETS + RSV_OCTETS;
      LAY_ANNOUNCE:         n = HDR_OCTETS + ANN_OCTETS;
      default:              n = HDR_OCTETS;
    endcase
    return n;
  endfunction

  function automatic fld_t mk_fld(input logic [4:0] tag, input logic [3:0] nb);
    fld_t f;
    f.hit    = 1'b1;
    f.tag    = tag;
    f.nbytes = nb;
    return f;
  endfunction

  // Field that ends at octet pos (pos >= 2)
  function automatic fld_t field_end(input logic [6:0] pos, input layout_t lay);
    fld_t f;
    f = '0;
    case (pos)
      7'd3:  f = mk_fld(TAG_MSG_LENGTH, 4'd2);
      7'd4:  f = mk_fld(TAG_DOMAIN,     4'd1);
      7'd7:  f = mk_fld(TAG_FLAGS,      4'd2);
      7'd15: f = mk_fld(TAG_CORRECTION, 4'd8);
      7'd27: f = mk_fld(TAG_CLOCK_ID,   4'd8);
      7'd29: f = mk_fld(TAG_PORT_NUM,   4'd2);
      7'd31: f = mk_fld(TAG_SEQ_ID,     4'd2);
      7'd32: f = mk_fld(TAG_CONTROL,    4'd1);
      7'd33: f = mk_fld(TAG_LOG_INTVL,  4'd1);
      default: f = '0;
    endcase
    if (!f.hit && lay != LAY_NONE) begin
      if (pos == 7'd39) begin
        f = mk_fld(TAG_TS_SEC, 4'd6);
      end else if (pos == 7'd43) begin
        f = mk_fld(TAG_TS_NSEC, 4'd4);
      end else if (lay == LAY_PORTID) begin
        case (pos)
          7'd51:   f = mk_fld(TAG_REQ_CLK_ID, 4'd8);
          7'd53:   f = mk_fld(TAG_REQ_PORT,   4'd2);
          default: f = '0;
        endcase
      end else if (lay == LAY_ANNOUNCE) begin
        case (pos)
          7'd45:   f = mk_fld(TAG_UTC_OFFSET, 4'd2);
          7'd47:   f = mk_fld(TAG_GM_PRIO1,   4'd1);
          7'd48:   f = mk_fld(TAG_CLK_CLASS,  4'd1);
          7'd49:   f = mk_fld(TAG_CLK_ACCUR,  4'd1);
          7'd51:   f = mk_fld(TAG_LOG_VAR,    4'd2);
          7'd52:   f = mk_fld(TAG_GM_PRIO2,   4'd1);
          7'd60:   f = mk_fld(TAG_GM_ID,      4'd8);
          7'd62:   f = mk_fld(TAG_STEPS_REM,  4'd2);
          7'd63:   f = mk_fld(TAG_TIME_SRC,   4'd1);
          default: f = '0;
        endcase
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    case (nb)
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ===== design/ptp_message_field_parser.sv =====
// ----------------------------------------------------------------------------
// ptp_message_field_parser
// Splits a PTPv2 message, one octet per transfer, into tagged header and body
// field records and closes each frame with a verdict record.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  in_     | input     | in_valid/in_stall | data_byte, frame_end
//  out_    | output    | out_valid/out_stall | field_tag, field_value, last_of_frame
//  cfg_    | input     | cfg_we            | accept_mask (16 bits)
//
// One octet is taken per cycle while in_stall is low. Its records are ready
// in the next cycle in a five-entry result queue that drains one record per
// cycle while out_stall is low; octet zero of a frame pushes two or three
// records, any other octet at most two. in_stall rises while the queue holds
// more than two records, so a stalled output backs up into the input.
// Synchronous reset clears offset, type, accumulator, queue and sets
// accept_mask to 0x0F0F.
module ptp_message_field_parser
  import pmfp_pkg::*;
#(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,

  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [6:0] MAX_OFS = 7'(MAX_OFFSET);

  logic [15:0] accept_mask_r;
  logic [6:0]  byte_offset_r, byte_offset_nxt;
  logic [3:0]  frame_type_r, frame_type_nxt;
  logic [63:0] field_accum_r, field_accum_nxt;

  out_item_t   q_r [QDEPTH];
  out_item_t   q_nxt [QDEPTH];
  logic [CW-1:0] count_r, count_nxt;

  logic        in_xfer, pop;
  logic [CW-1:0] base;

  out_item_t   push [MAX_PUSH];
  logic [1:0]  n_push;

  logic        in_range;
  layout_t     layout, layout_v;
  logic        accepted, accepted_v;
  fld_t        fld;
  logic [3:0]  type_v;
  logic [7:0]  len;
  logic [1:0]  code;
  logic [7:0]  b;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = count_r > CW'(QDEPTH - MAX_PUSH);
  assign out_valid = count_r != '0;
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign base      = count_r - CW'(pop);

  assign b        = in_data.data_byte;
  assign in_range = byte_offset_r < MAX_OFS;
  assign layout   = layout_of(frame_type_r);
  assign accepted = accept_mask_r[frame_type_r];
  assign fld      = field_end(byte_offset_r, layout);

  // Record generation for the octet at the input
  always_comb begin
    field_accum_nxt = field_accum_r;
    frame_type_nxt  = frame_type_r;
    n_push          = 2'd0;
    for (int i = 0; i < MAX_PUSH; i++) begin
      push[i] = '0;
    end

    if (in_range) begin
      field_accum_nxt = {field_accum_r[55:0], b};
      if (byte_offset_r == 7'd0) begin
        frame_type_nxt = b[3:0] & TYPE_MASK;
        push[0] = '{field_tag: TAG_MSG_TYPE, field_value: {60'd0, b[3:0]},
                    last_of_frame: 1'b0};
        push[1] = '{field_tag: TAG_TRANSPORT, field_value: {60'd0, b[7:4]},
                    last_of_frame: 1'b0};
        n_push  = 2'd2;
      end else if (byte_offset_r == 7'd1) begin
        push[0] = '{field_tag: TAG_VERSION, field_value: {60'd0, b[3:0]},
                    last_of_frame: 1'b0};
        n_push  = 2'd1;
      end else if (fld.hit && (fld.tag < TAG_TS_SEC || accepted)) begin
        push[0] = '{field_tag: fld.tag,
                    field_value: {field_accum_r[55:0], b} & byte_mask(fld.nbytes),
                    last_of_frame: 1'b0};
        n_push  = 2'd1;
      end
    end

    // Verdict: header short, then type not accepted, then body short
    type_v     = frame_type_nxt;
    layout_v   = layout_of(type_v);
    accepted_v = accept_mask_r[type_v];
    if (len < HDR_OCTETS) begin
      code = VERDICT_HDR_SHORT;
    end else if (!accepted_v) begin
      code = VERDICT_TYPE;
    end else if (len < needed_len(layout_v)) begin
      code = VERDICT_BODY_SHORT;
    end else begin
      code = VERDICT_OK;
    end
    if (in_data.frame_end) begin
      push[n_push] = '{field_tag: TAG_VERDICT, field_value: {62'd0, code},
                       last_of_frame: 1'b1};
      n_push       = n_push + 2'd1;
    end
  end

  // Saturating octet count
  assign len = in_range ? {1'b0, byte_offset_r} + 8'd1 : {1'b0, MAX_OFS};

  always_comb begin
    byte_offset_nxt = len[6:0];
    if (in_data.frame_end) begin
      byte_offset_nxt = '0;
    end
  end

  // Result queue: drop the head on an output transfer, append pushed records
  always_comb begin
    logic [CW-1:0] rel;
    for (int i = 0; i < QDEPTH; i++) begin
      rel = CW'(i) - base;
      if (pop && i < QDEPTH - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (in_xfer && CW'(i) >= base && rel < CW'(n_push)) begin
        q_nxt[i] = push[rel[1:0]];
      end
    end
    count_nxt = in_xfer ? base + CW'(n_push) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_mask_r <= ACCEPT_MASK_RST;
      byte_offset_r <= '0;
      frame_type_r  <= '0;
      field_accum_r <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_we) begin
        accept_mask_r <= cfg_wdata;
      end
      if (in_xfer) begin
        byte_offset_r <= byte_offset_nxt;
        if (in_data.frame_end) begin
          frame_type_r  <= '0;
          field_accum_r <= '0;
        end else begin
          frame_type_r  <= frame_type_nxt;
          field_accum_r <= field_accum_nxt;
        end
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("result queue overflow");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_offset_r <= MAX_OFS)
    else $error("octet offset past saturation point");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.frame_end |=> byte_offset_r == '0)
    else $error("offset not cleared after frame end");

  a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
    byte_offset_r == '0 |-> frame_type_r == '0 && field_accum_r == '0)
    else $error("frame state left over at frame start");

  a_last_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_of_frame == (out_data.field_tag == TAG_VERDICT))
    else $error("last_of_frame not on verdict record");
`endif

endmodule

// ===== tb/sv/ptp_field_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptp_field_checker
// Watches the octet and record channels of the PTPv2 field parser, predicts
// the field records that each accepted octet produces and compares every
// record that leaves the parser against the oldest prediction.
// ----------------------------------------------------------------------------
module ptp_field_checker
  import pmfp_pkg::*;
#(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          outstanding,
  output int          fail_count
);

  typedef struct packed {
    logic [4:0] tag;
    logic [3:0] nb;
  } slot_t;

  logic [15:0] accept_bits;
  logic [6:0]  octet_pos;
  logic [3:0]  msg_type;
  logic [63:0] accum;
  out_item_t   expected_fields[$];

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  function automatic layout_t body_of(input logic [3:0] mtype);
    case (mtype)
      MT_SYNC, MT_DELAY_REQ, MT_FOLLOW_UP:          return LAY_TS;
      MT_PDELAY_REQ:                                return LAY_PDREQ;
      MT_PDELAY_RESP, MT_DELAY_RESP, MT_PDELAY_RFU: return LAY_PORTID;
      MT_ANNOUNCE:                                  return LAY_ANNOUNCE;
      default:                                      return LAY_NONE;
    endcase
  endfunction

  function automatic int frame_need(input layout_t lay);
    case (lay)
      LAY_TS:                return int'(HDR_OCTETS) + int'(TS_OCTETS);
      LAY_PDREQ, LAY_PORTID: return int'(HDR_OCTETS) + int'(TS_OCTETS) + int'(RSV_OCTETS);
      LAY_ANNOUNCE:          return int'(HDR_OCTETS) + int'(ANN_OCTETS);
      default:               return int'(HDR_OCTETS);
    endcase
  endfunction

  // Field whose last octet sits at pos, or nb == 0 when none ends there
  function automatic slot_t slot_at(input int pos, input layout_t lay);
    slot_t s;
    bit    ann;
    bit    pid;
    bit    body;
    s    = '0;
    ann  = (lay == LAY_ANNOUNCE);
    pid  = (lay == LAY_PORTID);
    body = (lay != LAY_NONE);
    case (pos)
      3:  s = '{TAG_MSG_LENGTH, 4'd2};
      4:  s = '{TAG_DOMAIN, 4'd1};
      7:  s = '{TAG_FLAGS, 4'd2};
      15: s = '{TAG_CORRECTION, 4'd8};
      27: s = '{TAG_CLOCK_ID, 4'd8};
      29: s = '{TAG_PORT_NUM, 4'd2};
      31: s = '{TAG_SEQ_ID, 4'd2};
      32: s = '{TAG_CONTROL, 4'd1};
      33: s = '{TAG_LOG_INTVL, 4'd1};
      39: if (body) s = '{TAG_TS_SEC, 4'd6};
      43: if (body) s = '{TAG_TS_NSEC, 4'd4};
      45: if (ann) s = '{TAG_UTC_OFFSET, 4'd2};
      47: if (ann) s = '{TAG_GM_PRIO1, 4'd1};
      48: if (ann) s = '{TAG_CLK_CLASS, 4'd1};
      49: if (ann) s = '{TAG_CLK_ACCUR, 4'd1};
      51: begin
        if (pid) s = '{TAG_REQ_CLK_ID, 4'd8};
        else if (ann) s = '{TAG_LOG_VAR, 4'd2};
      end
      52: if (ann) s = '{TAG_GM_PRIO2, 4'd1};
      53: if (pid) s = '{TAG_REQ_PORT, 4'd2};
      60: if (ann) s = '{TAG_GM_ID, 4'd8};
      62: if (ann) s = '{TAG_STEPS_REM, 4'd2};
      63: if (ann) s = '{TAG_TIME_SRC, 4'd1};
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] width_mask(input logic [3:0] nb);
    if (nb >= 4'd8) return '1;
    return (64'd1 << (8 * nb)) - 64'd1;
  endfunction

  task automatic expect_field(input logic [4:0] tag, input logic [63:0] val,
                              input logic last);
    out_item_t r;
    r.field_tag     = tag;
    r.field_value   = val;
    r.last_of_frame = last;
    expected_fields.push_back(r);
  endtask

  task automatic parse_octet(input in_item_t it);
    int         pos;
    int         len;
    layout_t    lay;
    logic       ok;
    slot_t      s;
    logic [1:0] code;
    pos = octet_pos;
    lay = body_of(msg_type);
    ok  = accept_bits[msg_type];
    if (pos < MAX_OFFSET) begin
      accum = {accum[55:0], it.data_byte};
      if (pos == 0) begin
        msg_type = it.data_byte[3:0];
        expect_field(TAG_MSG_TYPE, 64'(it.data_byte[3:0]), 1'b0);
        expect_field(TAG_TRANSPORT, 64'(it.data_byte[7:4]), 1'b0);
      end else if (pos == 1) begin
        expect_field(TAG_VERSION, 64'(it.data_byte[3:0]), 1'b0);
      end else begin
        s = slot_at(pos, lay);
        // header fields always go out, body fields only for accepted types
        if (s.nb != 0 && (s.tag < TAG_TS_SEC || ok))
          expect_field(s.tag, accum & width_mask(s.nb), 1'b0);
      end
    end
    len = (pos + 1 > MAX_OFFSET) ? MAX_OFFSET : pos + 1;
    octet_pos = 7'(len);
    if (it.frame_end) begin
      if (len < HDR_OCTETS) code = VERDICT_HDR_SHORT;
      else if (!accept_bits[msg_type]) code = VERDICT_TYPE;
      else if (len < frame_need(body_of(msg_type))) code = VERDICT_BODY_SHORT;
      else code = VERDICT_OK;
      expect_field(TAG_VERDICT, 64'(code), 1'b1);
      octet_pos = '0;
      msg_type  = '0;
      accum     = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      accept_bits = ACCEPT_MASK_RST;
      octet_pos   = '0;
      msg_type    = '0;
      accum       = '0;
      expected_fields.delete();
    end else begin
      // compare before predicting: a record never leaves in its octet's cycle
      if (out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected record: expected none, got tag %0d value %h last %b",
                   $time, out_data.field_tag, out_data.field_value,
                   out_data.last_of_frame);
          fail_count++;
        end else begin
          want = expected_fields.pop_front();
          if (want !== out_data) begin
            $display(
              "%0t: expected tag %0d value %h last %b, got tag %0d value %h last %b",
              $time, want.field_tag, want.field_value, want.last_of_frame,
              out_data.field_tag, out_data.field_value, out_data.last_of_frame);
            fail_count++;
          end
        end
      end
      if (cfg_we) accept_bits = cfg_wdata;
      if (in_valid && !in_stall) parse_octet(in_data);
    end
    outstanding = expected_fields.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives whole PTPv2 messages into the field parser: a directed set of frame
// types and lengths, then random frames under several accept masks and idle
// patterns. The checker beside the parser does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import pmfp_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int HOLD_CYCLES      = 200;
  localparam int SETTLE_CYCLES    = 8;
  localparam int FRAMES_PER_PHASE = 2;

  // Message type with no body layout
  localparam logic [3:0] MT_SIGNALING  = 4'hC;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int outstanding;
  int fail_count;
  int send_idle;
  int recv_idle;
  int quiet_cycles = 0;
  bit hold_req;

  ptp_message_field_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ptp_field_checker #(.MAX_OFFSET(MAX_OFFSET_DEF)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record sink: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_octet(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, frame_end: last};
    // hold the payload until the transfer
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [3:0] mtype, input int len, input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (i == 0) b[3:0] = mtype;
      send_octet(b, i == len - 1);
    end
  endtask

  task automatic random_frame();
    int         pick;
    int         len;
    logic [3:0] mtype;
    mtype = 4'($urandom_range(15));
    pick  = $urandom_range(99);
    if (pick < 55) begin
      // land on or next to the length a layout needs
      case ($urandom_range(6))
        0:       len = 34;
        1:       len = 43;
        2:       len = 44;
        3:       len = 53;
        4:       len = 54;
        5:       len = 63;
        default: len = 64;
      endcase
    end else if (pick < 70) begin
      len = $urandom_range(1, 33);
    end else if (pick < 85) begin
      len = $urandom_range(34, 64);
    end else begin
      len = $urandom_range(65, 90);
    end
    send_frame(mtype, len, FILL_RANDOM);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // a trailing ignored octet may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_accept_mask(input logic [15:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // types 0-3 and 8-12 accepted: signaling passes on the header alone
    write_accept_mask(16'h1F0F);
    send_idle = 34;
    recv_idle = 53;
    send_frame(MT_ANNOUNCE, 1, FILL_ONES);
    send_frame(MT_SYNC, 33, FILL_ZERO);
    send_frame(MT_SIGNALING, 34, FILL_ONES);
    send_frame(MT_PDELAY_RESP, 53, FILL_RANDOM);
    send_frame(MT_ANNOUNCE, 70, FILL_ONES);
    wait_drained();

    write_accept_mask(16'hFFFF);
    for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
      if (n == 0) hold_req = 1'b1;
      random_frame();
    end
    wait_drained();

    write_accept_mask(16'h0000);
    send_idle = 53;
    recv_idle = 34;
    for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
      if (n == 1) wait_drained();
      random_frame();
    end
    wait_drained();

    write_accept_mask(16'($urandom));
    send_idle = 0;
    recv_idle = 0;
    for (int n = 0; n < FRAMES_PER_PHASE; n++) random_frame();
    wait_drained();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pmfp_pkg.sv
design/ptp_message_field_parser.sv
tb/sv/ptp_field_checker.sv
tb/sv/tb.sv
